/* design/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, codes and helpers for the rangeset string to bitset parser.
// ----------------------------------------------------------------------------
package rss_pkg;

  // widths of the fixed fields
  localparam int CHAR_W = 8;
  localparam int SET_W  = 32;
  localparam int STAT_W = 2;
  localparam int NUM_W  = 6;
  localparam int PH_W   = 3;

  // default top element of the set
  localparam int TOP_ELEMENT_DEF = 31;

  // parse phases
  localparam logic [PH_W-1:0] PH_EXPECT_FIRST  = 3'd0;
  localparam logic [PH_W-1:0] PH_IN_FIRST      = 3'd1;
  localparam logic [PH_W-1:0] PH_AFTER_FIRST   = 3'd2;
  localparam logic [PH_W-1:0] PH_EXPECT_SECOND = 3'd3;
  localparam logic [PH_W-1:0] PH_IN_SECOND     = 3'd4;
  localparam logic [PH_W-1:0] PH_AFTER_SECOND  = 3'd5;
  localparam logic [PH_W-1:0] PH_DRAIN         = 3'd6;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;

  // one result transaction
  typedef struct packed {
    logic [SET_W-1:0]  parsed_set;
    logic [STAT_W-1:0] parse_status;
  } rss_result_t;

  // decimal step result
  typedef struct packed {
    logic [NUM_W-1:0] val;
    logic             ovf;
  } dec_step_t;

  // one decimal digit into the accumulator, saturating at the top element
  function automatic dec_step_t dec_accum(input logic [NUM_W-1:0] acc,
                                          input logic [3:0]       dig,
                                          input logic [NUM_W-1:0] top);
    logic [9:0] v;
    dec_step_t  r;
    v = 10'(acc) * 10'd10 + 10'(dig);
    if (v > 10'(top)) begin
      r.val = top;
      r.ovf = 1'b1;
    end else begin
      r.val = v[NUM_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // c-locale whitespace
  function automatic logic is_ws(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

/* design/rss_in_stage.sv */
// ----------------------------------------------------------------------------
// rss_in_stage
// Input register: holds one character until the parser consumes it.
// ----------------------------------------------------------------------------
module rss_in_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rss_pkg::CHAR_W-1:0] in_char_code,
  input  logic                       advance,
  output logic                       hold_valid,
  output logic [rss_pkg::CHAR_W-1:0] hold_char
);
  import rss_pkg::*;

  logic              valid_r, valid_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              take;

  // free when empty or when the held character moves on this cycle
  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = take || (valid_r && !advance);
    char_nxt  = take ? in_char_code : char_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign hold_valid = valid_r;
  assign hold_char  = char_r;

endmodule

/* design/rss_parser.sv */
// ----------------------------------------------------------------------------
// rss_parser
// Per-character parse state update: numbers, ranges, flags and the set.
// ----------------------------------------------------------------------------
module rss_parser #(
  parameter int TOP_ELEMENT = rss_pkg::TOP_ELEMENT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic [rss_pkg::CHAR_W-1:0] char_code,
  input  logic [rss_pkg::SET_W-1:0]  allowed_mask,
  output logic                       emit,
  output rss_pkg::rss_result_t       result
);
  import rss_pkg::*;

  localparam logic [NUM_W-1:0] TOP_V = NUM_W'(TOP_ELEMENT);

  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [NUM_W-1:0] acc_r, acc_nxt;
  logic [NUM_W-1:0] lo_r, lo_nxt;
  logic [NUM_W-1:0] hi_r, hi_nxt;
  logic [SET_W-1:0] set_r, set_nxt;
  logic             inv_r, inv_nxt;
  logic             rng_r, rng_nxt;

  logic             c_dig, c_ws, done, fin;
  logic [3:0]       dval;
  dec_step_t        dstep, dfirst;
  logic             acc_ok;
  logic [SET_W-1:0] rbits;

  assign c_dig  = is_digit(char_code);
  assign c_ws   = is_ws(char_code);
  assign dval   = char_code[3:0];
  assign dstep  = dec_accum(acc_r, dval, TOP_V);
  assign dfirst = dec_accum('0, dval, TOP_V);
  // finished number must be below the set width and allowed
  assign acc_ok = !acc_r[NUM_W-1] && allowed_mask[acc_r[NUM_W-2:0]];

  // one character through the phase machine
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    set_nxt   = set_r;
    inv_nxt   = inv_r;
    rng_nxt   = rng_r;
    done      = 1'b0;
    fin       = 1'b0;
    rbits     = '0;

    // inside a number: extend it or close it
    if (phase_r == PH_IN_FIRST || phase_r == PH_IN_SECOND) begin
      if (c_dig) begin
        acc_nxt = dstep.val;
        rng_nxt = rng_r | dstep.ovf;
        done    = 1'b1;
      end else begin
        if (!acc_ok) begin
          rng_nxt = 1'b1;
        end
        hi_nxt = acc_r;
        if (phase_r == PH_IN_FIRST) begin
          lo_nxt    = acc_r;
          phase_nxt = PH_AFTER_FIRST;
        end else begin
          phase_nxt = PH_AFTER_SECOND;
        end
      end
    end

    if (!done) begin
      if (phase_nxt >= PH_DRAIN) begin
        // skip to end of string
        if (char_code == CH_NUL) begin
          fin = 1'b1;
        end else if (!c_ws) begin
          inv_nxt = 1'b1;
        end
      end else if (c_ws) begin
        // whitespace between tokens
      end else if ((phase_nxt == PH_EXPECT_FIRST || phase_nxt == PH_EXPECT_SECOND) &&
                   c_dig) begin
        acc_nxt   = dfirst.val;
        rng_nxt   = rng_nxt | dfirst.ovf;
        phase_nxt = (phase_nxt == PH_EXPECT_FIRST) ? PH_IN_FIRST : PH_IN_SECOND;
      end else if (phase_nxt == PH_AFTER_FIRST && char_code == CH_DASH) begin
        hi_nxt    = TOP_V;
        phase_nxt = PH_EXPECT_SECOND;
      end else begin
        // close the open term
        if (phase_nxt != PH_EXPECT_FIRST) begin
          if (lo_nxt <= hi_nxt) begin
            for (int i = 0; i < SET_W; i++) begin
              rbits[i] = (NUM_W'(i) >= lo_nxt) && (NUM_W'(i) <= hi_nxt);
            end
            set_nxt = (set_r | rbits) & allowed_mask;
          end else begin
            rng_nxt = 1'b1;
          end
          phase_nxt = PH_EXPECT_FIRST;
        end
        if (char_code == CH_COMMA || char_code == CH_SEMI) begin
          // separator
        end else if (char_code == CH_NUL) begin
          fin = 1'b1;
        end else begin
          inv_nxt   = 1'b1;
          phase_nxt = PH_DRAIN;
        end
      end
    end
  end

  // result from the final flags of this string
  always_comb begin
    if (inv_nxt) begin
      result.parsed_set   = '0;
      result.parse_status = STAT_INVALID;
    end else if (rng_nxt) begin
      result.parsed_set   = '1;
      result.parse_status = STAT_RANGE;
    end else begin
      result.parsed_set   = set_nxt;
      result.parse_status = STAT_OK;
    end
  end

  assign emit = fin;

  // state update, cleared after each end of string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_EXPECT_FIRST;
      acc_r   <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      set_r   <= '0;
      inv_r   <= 1'b0;
      rng_r   <= 1'b0;
    end else if (step_en) begin
      if (fin) begin
        phase_r <= PH_EXPECT_FIRST;
        acc_r   <= '0;
        lo_r    <= '0;
        hi_r    <= '0;
        set_r   <= '0;
        inv_r   <= 1'b0;
        rng_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        lo_r    <= lo_nxt;
        hi_r    <= hi_nxt;
        set_r   <= set_nxt;
        inv_r   <= inv_nxt;
        rng_r   <= rng_nxt;
      end
    end
  end

endmodule

/* design/rss_out_stage.sv */
// ----------------------------------------------------------------------------
// rss_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module rss_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  rss_pkg::rss_result_t       load_data,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rss_pkg::SET_W-1:0]  out_parsed_set,
  output logic [rss_pkg::STAT_W-1:0] out_parse_status
);
  import rss_pkg::*;

  logic        valid_r, valid_nxt;
  rss_result_t data_r, data_nxt;

  // slot opens when empty or drained this cycle
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = load || (valid_r && !out_ready);
    data_nxt  = load ? load_data : data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid        = valid_r;
  assign out_parsed_set   = data_r.parsed_set;
  assign out_parse_status = data_r.parse_status;

endmodule

/* design/rangeset_string_to_bitset.sv */
// Result path: an accepted NUL character is registered in the input register, then its
//   result in the result register (out_valid); the NUL waits until that register is free.
// Throughput: one char per cycle while no NUL waits; the parse state updates once per char.
// Reset: synchronous active-low rst_n clears the parse state and both stage valids
//   and sets allowed_mask to all ones.
// ----------------------------------------------------------------------------
// rangeset_string_to_bitset
// Streams a rangeset string one character at a time and returns its bitset and status.
// ----------------------------------------------------------------------------
module rangeset_string_to_bitset #(
  parameter int TOP_ELEMENT = rss_pkg::TOP_ELEMENT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [rss_pkg::CHAR_W-1:0] in_char_code,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rss_pkg::SET_W-1:0]  out_parsed_set,
  output logic [rss_pkg::STAT_W-1:0] out_parse_status,
  input  logic                       cfg_we,
  input  logic [rss_pkg::SET_W-1:0]  cfg_allowed_mask
);
  import rss_pkg::*;

  logic [SET_W-1:0]  mask_r, mask_nxt;
  logic              hold_valid;
  logic [CHAR_W-1:0] hold_char;
  logic              emit, out_free, advance;
  rss_result_t       result;

  // configuration register
  assign mask_nxt = cfg_we ? cfg_allowed_mask : mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '1;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  // a character moves on unless its result finds the output slot taken
  assign advance = hold_valid && (!emit || out_free);

  rss_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .advance      (advance),
    .hold_valid   (hold_valid),
    .hold_char    (hold_char)
  );

  rss_parser #(
    .TOP_ELEMENT (TOP_ELEMENT)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .char_code    (hold_char),
    .allowed_mask (mask_r),
    .emit         (emit),
    .result       (result)
  );

  rss_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (advance && emit),
    .load_data        (result),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_parsed_set   (out_parsed_set),
    .out_parse_status (out_parse_status)
  );

endmodule

/* design/rss_checker.sv */
// ----------------------------------------------------------------------------
// rss_checker
// Port-level checks on the result channel of the rangeset parser.
// ----------------------------------------------------------------------------
module rss_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rss_pkg::SET_W-1:0]  out_parsed_set,
  input logic [rss_pkg::STAT_W-1:0] out_parse_status
);
  import rss_pkg::*;

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_parsed_set) &&
                                $stable(out_parse_status))
    else $error("result changed while stalled");

  // only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_parse_status == STAT_OK) || (out_parse_status == STAT_INVALID) ||
                  (out_parse_status == STAT_RANGE))
    else $error("undefined status code");

  // invalid input gives an empty set
  a_invalid_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_parse_status == STAT_INVALID) |-> out_parsed_set == '0)
    else $error("invalid status with non-empty set");

  // range error gives a full set
  a_range_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_parse_status == STAT_RANGE) |-> out_parsed_set == '1)
    else $error("range status with set not full");

endmodule

bind rangeset_string_to_bitset rss_checker u_rss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_parsed_set   (out_parsed_set),
  .out_parse_status (out_parse_status)
);
